// File: rtl/core/bffa_pkg.sv
// Shared types and constants of the bitmap first-fit allocator.
`timescale 1ns / 1ps

package bffa_pkg;

   localparam int PAGE_BYTES_DEF  = 4096;
   localparam int CHUNK_BYTES_DEF = 8;

   localparam int FUNC_W   = 1;
   localparam int SIZE_W   = 13;
   localparam int OFFSET_W = 12;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 10;

   // wide enough for a chunk index or run length at the largest page
   localparam int ARG_W = 17;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [SIZE_W-1:0]   size_bytes;
      logic [OFFSET_W-1:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFFSET_W-1:0] alloc_offset;
      logic [COUNT_W-1:0]  freed_count;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_BAD_SIZE,
      CMD_ALLOC,
      CMD_FREE,
      CMD_FREE_NONE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [ARG_W-1:0] arg;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

// File: rtl/core/bffa_front.sv
// Request intake: divides by the chunk size and classifies each request into a command.
`timescale 1ns / 1ps

module bffa_front #(
   parameter int PAGE_BYTES  = bffa_pkg::PAGE_BYTES_DEF,
   parameter int CHUNK_BYTES = bffa_pkg::CHUNK_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bffa_pkg::req_type        req_data,
   input  bffa_pkg::back_status_type back_status,
   output logic                     cmd_valid,
   input  logic                     cmd_ready,
   output bffa_pkg::cmd_type        cmd_data
);

   localparam int DW      = bffa_pkg::SIZE_W;
   localparam int LOG_DIV = $clog2(CHUNK_BYTES);
   localparam int SHIFT   = DW + LOG_DIV;
   localparam int MUL_W   = DW + 2;
   localparam int PROD_W  = DW + MUL_W;
   localparam longint RECIP_INT =
      ((longint'(1) << SHIFT) + longint'(CHUNK_BYTES) - longint'(1)) / longint'(CHUNK_BYTES);
   localparam logic [MUL_W-1:0] RECIP   = MUL_W'(RECIP_INT);
   localparam logic [DW-1:0]    DIVISOR = DW'(CHUNK_BYTES);

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_REM,
      F_PUSH
   } state_type;

   state_type          state_ff, state_in;
   bffa_pkg::req_type  req_ff, req_in;
   logic [DW-1:0]      dvd_ff, dvd_in;
   logic [DW-1:0]      rem_ff, rem_in;
   logic [DW-1:0]      num;
   logic [PROD_W-1:0]  quo_prod;
   logic [PROD_W-1:0]  quo_shift;
   logic [2*DW-1:0]    back_prod;
   logic               size_bad;
   logic               offset_out;

   assign req_ready = (state_ff == F_IDLE) && !back_status.clearing;
   assign cmd_valid = (state_ff == F_PUSH);

   assign num       = (req_ff.func == bffa_pkg::FUNC_FREE) ?
                      DW'(req_ff.free_offset) : req_ff.size_bytes;
   assign quo_prod  = PROD_W'(dvd_ff) * PROD_W'(RECIP);
   assign quo_shift = quo_prod >> SHIFT;
   assign back_prod = (2 * DW)'(dvd_ff) * (2 * DW)'(DIVISOR);

   assign size_bad = (req_ff.size_bytes == '0) || (rem_ff != '0) ||
                     (32'(req_ff.size_bytes) > 32'(PAGE_BYTES));
   assign offset_out = 32'(req_ff.free_offset) >= 32'(PAGE_BYTES);

   always_comb begin
      cmd_data.arg = bffa_pkg::ARG_W'(dvd_ff);
      if (req_ff.func == bffa_pkg::FUNC_FREE) begin
         cmd_data.kind = offset_out ? bffa_pkg::CMD_FREE_NONE : bffa_pkg::CMD_FREE;
      end else begin
         cmd_data.kind = size_bad ? bffa_pkg::CMD_BAD_SIZE : bffa_pkg::CMD_ALLOC;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid && req_ready) begin
               req_in  = req_data;
               dvd_in  = (req_data.func == bffa_pkg::FUNC_FREE) ?
                         DW'(req_data.free_offset) : req_data.size_bytes;
               rem_in  = '0;
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            dvd_in   = quo_shift[DW-1:0];
            state_in = F_REM;
         end
         F_REM: begin
            rem_in   = num - back_prod[DW-1:0];
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (cmd_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff  <= req_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
   end

endmodule

// File: rtl/core/bffa_cmd_queue.sv
// Short command queue between the intake and the map engine.
`timescale 1ns / 1ps

module bffa_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  bffa_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output bffa_pkg::cmd_type pop_data
);

   localparam int DEPTH = bffa_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   bffa_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/bffa_back.sv
// Map engine: free-bit and run-length memories, first-fit scan, release and result register.
`timescale 1ns / 1ps

module bffa_back #(
   parameter int PAGE_BYTES  = bffa_pkg::PAGE_BYTES_DEF,
   parameter int CHUNK_BYTES = bffa_pkg::CHUNK_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  bffa_pkg::cmd_type         cmd_data,
   output bffa_pkg::back_status_type back_status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bffa_pkg::rsp_type         rsp_data
);

   localparam int NUM_CHUNKS = PAGE_BYTES / CHUNK_BYTES;
   localparam int IDX_W      = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int CNT_W      = $clog2(NUM_CHUNKS + 1);
   localparam logic [CNT_W-1:0] NUM_C  = CNT_W'(NUM_CHUNKS);
   localparam logic [CNT_W-1:0] LAST_C = CNT_W'(NUM_CHUNKS - 1);

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_SCAN,
      B_MARK,
      B_FREE_RD,
      B_FREE_LEN,
      B_FREE_RUN,
      B_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   need_ff, need_in;
   logic [CNT_W-1:0]   start_ff, start_in;
   logic [CNT_W-1:0]   freed_ff, freed_in;
   logic               chk_v_ff, chk_v_in;
   logic [CNT_W-1:0]   chk_idx_ff, chk_idx_in;
   bffa_pkg::rsp_type  res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bffa_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic               free_map_ff [NUM_CHUNKS];
   logic [CNT_W-1:0]   run_length_ff [NUM_CHUNKS];
   logic               fm_rdata_ff;
   logic [CNT_W-1:0]   rl_rdata_ff;

   logic               fm_we;
   logic [IDX_W-1:0]   fm_waddr;
   logic               fm_wdata;
   logic [IDX_W-1:0]   fm_raddr;
   logic               rl_we;
   logic [IDX_W-1:0]   rl_waddr;
   logic [CNT_W-1:0]   rl_wdata;
   logic [IDX_W-1:0]   rl_raddr;

   logic [CNT_W-1:0]   streak;
   logic [31:0]        ofs_full;
   logic [31:0]        freed_wide;

   assign cmd_ready            = (state_ff == B_IDLE);
   assign back_status.clearing = (state_ff == B_CLEAR);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data             = rsp_data_ff;

   assign streak     = fm_rdata_ff ? cnt_ff + CNT_W'(1) : '0;
   assign ofs_full   = 32'(start_ff) * 32'(CHUNK_BYTES);
   assign freed_wide = 32'(freed_ff);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      need_in      = need_ff;
      start_in     = start_ff;
      freed_in     = freed_ff;
      chk_v_in     = 1'b0;
      chk_idx_in   = chk_idx_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      fm_we        = 1'b0;
      fm_waddr     = addr_ff[IDX_W-1:0];
      fm_wdata     = 1'b0;
      fm_raddr     = '0;
      rl_we        = 1'b0;
      rl_waddr     = addr_ff[IDX_W-1:0];
      rl_wdata     = '0;
      rl_raddr     = addr_ff[IDX_W-1:0];
      case (state_ff)
         B_CLEAR: begin
            fm_we    = 1'b1;
            fm_wdata = 1'b1;
            rl_we    = 1'b1;
            addr_in  = addr_ff + CNT_W'(1);
            if (addr_ff == LAST_C) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (cmd_valid) begin
               case (cmd_data.kind)
                  bffa_pkg::CMD_ALLOC: begin
                     need_in  = cmd_data.arg[CNT_W-1:0];
                     addr_in  = '0;
                     cnt_in   = '0;
                     state_in = B_SCAN;
                  end
                  bffa_pkg::CMD_FREE: begin
                     addr_in  = cmd_data.arg[CNT_W-1:0];
                     state_in = B_FREE_RD;
                  end
                  bffa_pkg::CMD_BAD_SIZE: begin
                     res_in   = '{status: bffa_pkg::ST_BAD_SIZE, default: '0};
                     state_in = B_RESP;
                  end
                  default: begin
                     res_in   = '{status: bffa_pkg::ST_OK, default: '0};
                     state_in = B_RESP;
                  end
               endcase
            end
         end
         B_SCAN: begin
            if (addr_ff < NUM_C) begin
               fm_raddr   = addr_ff[IDX_W-1:0];
               chk_v_in   = 1'b1;
               chk_idx_in = addr_ff;
               addr_in    = addr_ff + CNT_W'(1);
            end
            if (chk_v_ff) begin
               cnt_in = streak;
               if (streak == need_ff) begin
                  start_in = chk_idx_ff + CNT_W'(1) - need_ff;
                  addr_in  = chk_idx_ff + CNT_W'(1) - need_ff;
                  cnt_in   = need_ff;
                  chk_v_in = 1'b0;
                  state_in = B_MARK;
               end else if (chk_idx_ff == LAST_C) begin
                  res_in   = '{status: bffa_pkg::ST_NO_SPACE, default: '0};
                  chk_v_in = 1'b0;
                  state_in = B_RESP;
               end
            end
         end
         B_MARK: begin
            fm_we    = 1'b1;
            fm_wdata = 1'b0;
            rl_we    = 1'b1;
            rl_waddr = start_ff[IDX_W-1:0];
            rl_wdata = need_ff;
            addr_in  = addr_ff + CNT_W'(1);
            cnt_in   = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               res_in.status       = bffa_pkg::ST_OK;
               res_in.alloc_offset = ofs_full[bffa_pkg::OFFSET_W-1:0];
               res_in.freed_count  = '0;
               state_in            = B_RESP;
            end
         end
         B_FREE_RD: begin
            state_in = B_FREE_LEN;
         end
         B_FREE_LEN: begin
            rl_we    = 1'b1;
            cnt_in   = rl_rdata_ff;
            freed_in = '0;
            state_in = B_FREE_RUN;
         end
         B_FREE_RUN: begin
            if ((cnt_ff != '0) && (addr_ff < NUM_C)) begin
               fm_we    = 1'b1;
               fm_wdata = 1'b1;
               addr_in  = addr_ff + CNT_W'(1);
               cnt_in   = cnt_ff - CNT_W'(1);
               freed_in = freed_ff + CNT_W'(1);
            end else begin
               res_in.status       = bffa_pkg::ST_OK;
               res_in.alloc_offset = '0;
               res_in.freed_count  = freed_wide[bffa_pkg::COUNT_W-1:0];
               state_in            = B_RESP;
            end
         end
         B_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         addr_ff      <= '0;
         chk_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         chk_v_ff     <= chk_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      need_ff     <= need_in;
      start_ff    <= start_in;
      freed_ff    <= freed_in;
      chk_idx_ff  <= chk_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (fm_we) begin
         free_map_ff[fm_waddr] <= fm_wdata;
      end
      fm_rdata_ff <= free_map_ff[fm_raddr];
   end

   always_ff @(posedge clock) begin
      if (rl_we) begin
         run_length_ff[rl_waddr] <= rl_wdata;
      end
      rl_rdata_ff <= run_length_ff[rl_raddr];
   end

endmodule

// File: rtl/core/bitmap_first_fit_allocator_core.sv
// Top level of the bitmap first-fit chunk allocator.
`timescale 1ns / 1ps

// One page of PAGE_BYTES is managed as PAGE_BYTES / CHUNK_BYTES chunks, each with a
// free bit and a run-length record held in memories with one write and one read
// port. After reset a clearing pass writes both memories, one chunk per cycle;
// req_ready stays low until it ends. Every request gives one result. Intake turns
// the size or offset into chunks with a reciprocal multiply and then a check
// multiply, and a two-entry command queue lets it take the next request while the
// map engine works. An allocate then scans the free map at one chunk per cycle from
// chunk 0 up to the end of the first fitting run, and marks the run at one chunk
// per cycle. A free reads the record and releases the run at one chunk per cycle.
// The result waits in an output register until taken.
module bitmap_first_fit_allocator_core #(
   parameter int PAGE_BYTES  = bffa_pkg::PAGE_BYTES_DEF,
   parameter int CHUNK_BYTES = bffa_pkg::CHUNK_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bffa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bffa_pkg::rsp_type rsp_data
);

   bffa_pkg::back_status_type back_status;
   logic                      push_valid;
   logic                      push_ready;
   bffa_pkg::cmd_type         push_data;
   logic                      pop_valid;
   logic                      pop_ready;
   bffa_pkg::cmd_type         pop_data;

   bffa_front #(
      .PAGE_BYTES  (PAGE_BYTES),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .back_status (back_status),
      .cmd_valid   (push_valid),
      .cmd_ready   (push_ready),
      .cmd_data    (push_data)
   );

   bffa_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bffa_back #(
      .PAGE_BYTES  (PAGE_BYTES),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (pop_valid),
      .cmd_ready   (pop_ready),
      .cmd_data    (pop_data),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
